// ===== rtl/hsv2rgb_pkg.sv =====
`default_nettype none

package hsv2rgb_pkg;

  // Width of the hue field on the input word.
  localparam int HUE_W = 16;

  // Hue geometry in whole degrees.
  localparam int SECTOR_DEG = 60;
  localparam int CIRCLE_DEG = 360;
  localparam int NUM_SECTORS = CIRCLE_DEG / SECTOR_DEG;

  // Helper levels computed side by side through the datapath.
  localparam int NUM_LVL = 3;
  localparam int LVL_P = 0;
  localparam int LVL_Q = 1;
  localparam int LVL_T = 2;

  // Number of register stages from input to the output register.
  localparam int NSTG = 8;

  // 60-degree hue sector.
  typedef enum logic [2:0] {
    SECT_0,
    SECT_1,
    SECT_2,
    SECT_3,
    SECT_4,
    SECT_5
  } sector_t;

endpackage

`default_nettype wire

// ===== rtl/hsv_to_rgb_converter.sv =====
`default_nettype none

// HSV to RGB pixel converter. One HSV pixel goes in per word and one RGB pixel comes out per
// word, in order. Hue is in units of 1/2^HUE_FRAC_BITS degree (1/64 degree by default) and
// any hue of 360 degrees or more is taken as 0; saturation and brightness are fractions of
// 2^CHANNEL_BITS - 1. The block sustains one pixel per clock: a new word is taken in every
// cycle in which the pipeline has a free slot, and a result waiting on the output does not
// block intake until all eight stages are full. An accepted word passes through the eight
// register stages of the arithmetic pipeline (sector split, saturation products, difference,
// brightness multiply, scale, reciprocal multiply, back multiply, correction and channel
// select) and is held in the output register, the last of them, until it is taken. Each of
// the p, q and t levels is rounded to nearest with halves rounded up; zero saturation gives
// grey equal to brightness.
module hsv_to_rgb_converter #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int CHANNEL_BITS  = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // Fields from bit 0 up: hue, saturation, brightness; zero padded to whole bytes.
  input  wire logic [((hsv2rgb_pkg::HUE_W + 2*CHANNEL_BITS + 7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // Fields from bit 0 up: red, green, blue; zero padded to whole bytes.
  output logic [((3*CHANNEL_BITS + 7)/8)*8-1:0] out_tdata
);

  localparam int CB    = CHANNEL_BITS;
  localparam int HF    = HUE_FRAC_BITS;
  localparam int HW    = hsv2rgb_pkg::HUE_W;
  localparam int NSTG  = hsv2rgb_pkg::NSTG;
  localparam int NLVL  = hsv2rgb_pkg::NUM_LVL;
  localparam int OUT_W = ((3*CHANNEL_BITS + 7)/8)*8;

  // Channel full scale, sector width and full circle in hue units.
  localparam longint unsigned CH_MAX    = (64'd1 << CB) - 64'd1;
  localparam longint unsigned SECT_W    = 64'(hsv2rgb_pkg::SECTOR_DEG) << HF;
  localparam longint unsigned HUE_LIMIT = 64'(hsv2rgb_pkg::CIRCLE_DEG) << HF;
  localparam int              SW        = $clog2(SECT_W + 64'd1);

  // Common denominator of all three levels and the widths that follow from it.
  localparam longint unsigned DEN = CH_MAX * SECT_W;
  localparam int              DW  = CB + SW;
  localparam int              NW  = CB + DW;

  // The denominator is KDIV * 2^SH, so the power of two comes off as a shift first.
  localparam int              SH   = HF + 2;
  localparam int              YW   = NW - SH;
  localparam longint unsigned KDIV = CH_MAX * (SECT_W >> SH);
  localparam int              KW   = $clog2(KDIV + 64'd1);

  // Reciprocal of KDIV scaled by 2^YW; the estimate it gives is low by at most one.
  localparam longint unsigned RECIP = (64'd1 << YW) / KDIV;
  localparam int              RW    = YW - KW + 1;
  localparam int              PW    = YW + RW;
  localparam int              KP    = CB + KW;
  localparam int              XW    = (YW > KP) ? YW : KP;

  // Handshake and per-stage valid bits.
  logic [NSTG:1] v_r;
  logic [NSTG:1] v_in;
  logic [NSTG:1] adv;

  // Payload carried alongside the arithmetic.
  logic [NSTG:1][CB-1:0]   val_r;
  hsv2rgb_pkg::sector_t    sect_r [1:NSTG-1];

  // Input fields.
  logic [HW-1:0] hue_in;
  logic [CB-1:0] sat_in;
  logic [CB-1:0] val_in;

  // Stage 1: sector split.
  logic [HW-1:0]         hue_w;
  logic [HW-1:0]         base;
  hsv2rgb_pkg::sector_t  sect1_nxt;
  logic [SW-1:0]         rem1_nxt;
  logic [SW-1:0]         rem1_r;
  logic [CB-1:0]         sat1_r;

  // Stages 2 to 8: per-level datapath.
  logic [NLVL-1:0][SW-1:0] opnd2;
  logic [NLVL-1:0][DW-1:0] prd2_nxt, prd2_r;
  logic [NLVL-1:0][DW-1:0] dif3_nxt, dif3_r;
  logic [NLVL-1:0][NW-1:0] num4_nxt, num4_r;
  logic [NLVL-1:0][YW-1:0] y5_nxt, y5_r;
  logic [NLVL-1:0][PW-1:0] est6;
  logic [NLVL-1:0][CB-1:0] qe6_nxt, qe6_r;
  logic [NLVL-1:0][YW-1:0] y6_r;
  logic [NLVL-1:0][KP-1:0] pk7_nxt, pk7_r;
  logic [NLVL-1:0][YW-1:0] y7_r;
  logic [NLVL-1:0][CB-1:0] qe7_r;
  logic [NLVL-1:0][XW-1:0] rr8;
  logic [NLVL-1:0][CB-1:0] lvl8;

  logic [CB-1:0] red_nxt, green_nxt, blue_nxt;
  logic [CB-1:0] red_r, green_r, blue_r;

  assign hue_in = in_tdata[HW-1:0];
  assign sat_in = in_tdata[HW +: CB];
  assign val_in = in_tdata[HW+CB +: CB];

  // A stage moves forward when it is empty or the stage after it moves, so bubbles close up
  // and intake continues while the output word waits.
  always_comb begin
    adv[NSTG] = !v_r[NSTG] || out_tready;
    for (int s = NSTG - 1; s >= 1; s--) begin
      adv[s] = !v_r[s] || adv[s+1];
    end
  end

  assign in_tready = adv[1];
  assign v_in      = {v_r[NSTG-1:1], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 1; s <= NSTG; s++) begin
        if (adv[s]) begin
          v_r[s] <= v_in[s];
        end
      end
    end
  end

  // Stage 1: fold an out-of-range hue to zero, then find the sector by comparing against the
  // five sector boundaries in parallel and keep the remainder inside the sector.
  always_comb begin
    hue_w     = (64'(hue_in) >= HUE_LIMIT) ? '0 : hue_in;
    base      = '0;
    sect1_nxt = hsv2rgb_pkg::SECT_0;
    for (int k = 1; k < hsv2rgb_pkg::NUM_SECTORS; k++) begin
      if (64'(hue_w) >= 64'(k) * SECT_W) begin
        sect1_nxt = hsv2rgb_pkg::sector_t'(3'(k));
        base      = HW'(64'(k) * SECT_W);
      end
    end
    rem1_nxt = SW'(hue_w - base);
  end

  // Stage 2: saturation times the hue offset of each level. The p level uses a full sector,
  // which makes it the same formula as q and lets all three share one datapath.
  always_comb begin
    opnd2[hsv2rgb_pkg::LVL_P] = SW'(SECT_W);
    opnd2[hsv2rgb_pkg::LVL_Q] = rem1_r;
    opnd2[hsv2rgb_pkg::LVL_T] = SW'(SECT_W) - rem1_r;
    for (int c = 0; c < NLVL; c++) begin
      prd2_nxt[c] = DW'(DW'(sat1_r) * DW'(opnd2[c]));
    end
  end

  // Stages 3 to 5: subtract from the denominator, scale by brightness, add half the
  // denominator for rounding and drop its power-of-two factor.
  always_comb begin
    for (int c = 0; c < NLVL; c++) begin
      dif3_nxt[c] = DW'(DEN) - prd2_r[c];
      num4_nxt[c] = NW'(NW'(val_r[3]) * NW'(dif3_r[c]));
      y5_nxt[c]   = YW'((num4_r[c] + NW'(DEN / 2)) >> SH);
    end
  end

  // Stages 6 to 8: quotient estimate from the reciprocal, back multiply, then one
  // correction step when the remainder still holds a whole divisor.
  always_comb begin
    for (int c = 0; c < NLVL; c++) begin
      est6[c]    = PW'(PW'(y5_r[c]) * PW'(RECIP));
      qe6_nxt[c] = est6[c][YW +: CB];
      pk7_nxt[c] = KP'(KP'(qe6_r[c]) * KP'(KDIV));
      rr8[c]     = XW'(y7_r[c]) - XW'(pk7_r[c]);
      lvl8[c]    = (rr8[c] >= XW'(KDIV)) ? qe7_r[c] + CB'(1) : qe7_r[c];
    end
  end

  // Channel order by sector.
  always_comb begin
    case (sect_r[NSTG-1])
      hsv2rgb_pkg::SECT_0: begin
        red_nxt   = val_r[NSTG-1];
        green_nxt = lvl8[hsv2rgb_pkg::LVL_T];
        blue_nxt  = lvl8[hsv2rgb_pkg::LVL_P];
      end
      hsv2rgb_pkg::SECT_1: begin
        red_nxt   = lvl8[hsv2rgb_pkg::LVL_Q];
        green_nxt = val_r[NSTG-1];
        blue_nxt  = lvl8[hsv2rgb_pkg::LVL_P];
      end
      hsv2rgb_pkg::SECT_2: begin
        red_nxt   = lvl8[hsv2rgb_pkg::LVL_P];
        green_nxt = val_r[NSTG-1];
        blue_nxt  = lvl8[hsv2rgb_pkg::LVL_T];
      end
      hsv2rgb_pkg::SECT_3: begin
        red_nxt   = lvl8[hsv2rgb_pkg::LVL_P];
        green_nxt = lvl8[hsv2rgb_pkg::LVL_Q];
        blue_nxt  = val_r[NSTG-1];
      end
      hsv2rgb_pkg::SECT_4: begin
        red_nxt   = lvl8[hsv2rgb_pkg::LVL_T];
        green_nxt = lvl8[hsv2rgb_pkg::LVL_P];
        blue_nxt  = val_r[NSTG-1];
      end
      default: begin
        red_nxt   = val_r[NSTG-1];
        green_nxt = lvl8[hsv2rgb_pkg::LVL_P];
        blue_nxt  = lvl8[hsv2rgb_pkg::LVL_Q];
      end
    endcase
  end

  // Payload registers; each stage loads whenever it moves.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      val_r[1]  <= val_in;
      sect_r[1] <= sect1_nxt;
      rem1_r    <= rem1_nxt;
      sat1_r    <= sat_in;
    end
    for (int s = 2; s <= NSTG; s++) begin
      if (adv[s]) begin
        val_r[s] <= val_r[s-1];
      end
    end
    for (int s = 2; s <= NSTG - 1; s++) begin
      if (adv[s]) begin
        sect_r[s] <= sect_r[s-1];
      end
    end
    if (adv[2]) begin
      prd2_r <= prd2_nxt;
    end
    if (adv[3]) begin
      dif3_r <= dif3_nxt;
    end
    if (adv[4]) begin
      num4_r <= num4_nxt;
    end
    if (adv[5]) begin
      y5_r <= y5_nxt;
    end
    if (adv[6]) begin
      qe6_r <= qe6_nxt;
      y6_r  <= y5_r;
    end
    if (adv[7]) begin
      pk7_r <= pk7_nxt;
      qe7_r <= qe6_r;
      y7_r  <= y6_r;
    end
    if (adv[8]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_tvalid = v_r[NSTG];
  assign out_tdata  = OUT_W'({blue_r, green_r, red_r});

  // Any empty stage must leave room for a new input word.
  a_intake_open: assert property (@(posedge clk) disable iff (!rst_n)
    !(&v_r) |-> in_tready)
    else $error("input stalled while the pipeline has a free slot");

  // The reciprocal estimate is never more than one below the true quotient.
  a_est_close: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NSTG-1] |-> (rr8[0] < XW'(2 * KDIV)) && (rr8[1] < XW'(2 * KDIV))
                    && (rr8[2] < XW'(2 * KDIV)))
    else $error("quotient estimate off by more than one");

  // The brightest channel of every result equals the brightness it came with.
  a_max_is_value: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NSTG] |-> (red_r == val_r[NSTG]) || (green_r == val_r[NSTG])
                  || (blue_r == val_r[NSTG]))
    else $error("no output channel carries the brightness");

endmodule

`default_nettype wire
